@@ hw/rtl/tmhpq_pkg.sv @@
// Shared widths, codes, entry type and the sequencer microprogram for the ternary min-heap.
package tmhpq_pkg;

  localparam int CAPACITY = 4096;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CHILD_W  = IDX_W + 2;
  localparam int VERTEX_W = 20;
  localparam int KEY_W    = 31;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 13;

  localparam logic KIND_POP = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [VERTEX_W-1:0] vertex;
    logic [KEY_W-1:0]    key;
  } entry_t;

  localparam int STEP_W = 5;

  localparam logic [STEP_W-1:0] S_IDLE   = 5'd0;
  localparam logic [STEP_W-1:0] S_INS    = 5'd1;
  localparam logic [STEP_W-1:0] S_INC    = 5'd2;
  localparam logic [STEP_W-1:0] S_UP     = 5'd3;
  localparam logic [STEP_W-1:0] S_UP_RD  = 5'd4;
  localparam logic [STEP_W-1:0] S_UP_CMP = 5'd5;
  localparam logic [STEP_W-1:0] S_UP_MOV = 5'd6;
  localparam logic [STEP_W-1:0] S_POP    = 5'd7;
  localparam logic [STEP_W-1:0] S_ROOT   = 5'd8;
  localparam logic [STEP_W-1:0] S_LAST   = 5'd9;
  localparam logic [STEP_W-1:0] S_LD_CUR = 5'd10;
  localparam logic [STEP_W-1:0] S_DOWN   = 5'd11;
  localparam logic [STEP_W-1:0] S_CH0    = 5'd12;
  localparam logic [STEP_W-1:0] S_CH1    = 5'd13;
  localparam logic [STEP_W-1:0] S_CH2    = 5'd14;
  localparam logic [STEP_W-1:0] S_DN_CMP = 5'd15;
  localparam logic [STEP_W-1:0] S_DN_MOV = 5'd16;
  localparam logic [STEP_W-1:0] S_PLACE  = 5'd17;
  localparam logic [STEP_W-1:0] S_FULL   = 5'd18;
  localparam logic [STEP_W-1:0] S_EMPTY  = 5'd19;

  localparam logic [3:0] C_NEXT         = 4'd0;
  localparam logic [3:0] C_ALWAYS       = 4'd1;
  localparam logic [3:0] C_POP          = 4'd2;
  localparam logic [3:0] C_FULL         = 4'd3;
  localparam logic [3:0] C_EMPTY        = 4'd4;
  localparam logic [3:0] C_POS_ZERO     = 4'd5;
  localparam logic [3:0] C_CUR_NLT_RD   = 4'd6;
  localparam logic [3:0] C_FIRST_GE     = 4'd7;
  localparam logic [3:0] C_BEST_NLT_CUR = 4'd8;

  localparam logic [2:0] RD_NONE  = 3'd0;
  localparam logic [2:0] RD_PAR   = 3'd1;
  localparam logic [2:0] RD_ROOT  = 3'd2;
  localparam logic [2:0] RD_LAST  = 3'd3;
  localparam logic [2:0] RD_FIRST = 3'd4;
  localparam logic [2:0] RD_NEXT  = 3'd5;

  localparam logic [1:0] WR_NONE = 2'd0;
  localparam logic [1:0] WR_CUR  = 2'd1;
  localparam logic [1:0] WR_RD   = 2'd2;
  localparam logic [1:0] WR_BEST = 2'd3;

  localparam logic [1:0] POS_KEEP = 2'd0;
  localparam logic [1:0] POS_PAR  = 2'd1;
  localparam logic [1:0] POS_BEST = 2'd2;
  localparam logic [1:0] POS_ZERO = 2'd3;

  typedef struct packed {
    logic [3:0]          cond;
    logic [STEP_W-1:0]   target;
    logic [2:0]          rd_sel;
    logic [1:0]          wr_sel;
    logic [1:0]          pos_sel;
    logic                ld_par;
    logic                cnt_inc;
    logic                cnt_dec;
    logic                ld_res;
    logic                ld_cur;
    logic                ld_best;
    logic                cmp_child;
    logic                cidx_first;
    logic                cidx_inc;
    logic                finish;
    logic [STATUS_W-1:0] st;
  } uword_t;

  function automatic uword_t ucode(input logic [STEP_W-1:0] s);
    uword_t w;
    w            = '0;
    w.cond       = C_NEXT;
    w.target     = S_IDLE;
    w.rd_sel     = RD_NONE;
    w.wr_sel     = WR_NONE;
    w.pos_sel    = POS_KEEP;
    w.st         = ST_DONE;
    unique case (s)
      S_IDLE: begin
        w.cond = C_POP;  w.target = S_POP;
      end
      S_INS: begin
        w.cond = C_FULL; w.target = S_FULL;
      end
      S_INC: begin
        w.cnt_inc = 1'b1;
      end
      S_UP: begin
        w.ld_par = 1'b1; w.cond = C_POS_ZERO; w.target = S_PLACE;
      end
      S_UP_RD: begin
        w.rd_sel = RD_PAR;
      end
      S_UP_CMP: begin
        w.cond = C_CUR_NLT_RD; w.target = S_PLACE;
      end
      S_UP_MOV: begin
        w.wr_sel = WR_RD; w.pos_sel = POS_PAR; w.cond = C_ALWAYS; w.target = S_UP;
      end
      S_POP: begin
        w.rd_sel = RD_ROOT; w.cond = C_EMPTY; w.target = S_EMPTY;
      end
      S_ROOT: begin
        w.ld_res = 1'b1; w.cnt_dec = 1'b1;
      end
      S_LAST: begin
        w.rd_sel = RD_LAST; w.pos_sel = POS_ZERO;
      end
      S_LD_CUR: begin
        w.ld_cur = 1'b1;
      end
      S_DOWN: begin
        w.rd_sel = RD_FIRST; w.cidx_first = 1'b1;
        w.cond = C_FIRST_GE; w.target = S_PLACE;
      end
      S_CH0: begin
        w.ld_best = 1'b1; w.rd_sel = RD_NEXT; w.cidx_inc = 1'b1;
      end
      S_CH1: begin
        w.cmp_child = 1'b1; w.rd_sel = RD_NEXT; w.cidx_inc = 1'b1;
      end
      S_CH2: begin
        w.cmp_child = 1'b1;
      end
      S_DN_CMP: begin
        w.cond = C_BEST_NLT_CUR; w.target = S_PLACE;
      end
      S_DN_MOV: begin
        w.wr_sel = WR_BEST; w.pos_sel = POS_BEST; w.cond = C_ALWAYS; w.target = S_DOWN;
      end
      S_PLACE: begin
        w.wr_sel = WR_CUR; w.finish = 1'b1; w.st = ST_DONE;
        w.cond = C_ALWAYS; w.target = S_IDLE;
      end
      S_FULL: begin
        w.finish = 1'b1; w.st = ST_FULL; w.cond = C_ALWAYS; w.target = S_IDLE;
      end
      S_EMPTY: begin
        w.finish = 1'b1; w.st = ST_EMPTY; w.cond = C_ALWAYS; w.target = S_IDLE;
      end
      default: begin
        w.cond = C_ALWAYS; w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

@@ hw/rtl/tmhpq_cmd_if.sv @@
// Command channel interface: operation kind and the entry to insert.
interface tmhpq_cmd_if import tmhpq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                kind;
  logic [VERTEX_W-1:0] entry_vertex;
  logic [KEY_W-1:0]    entry_key;

  modport source (output valid, kind, entry_vertex, entry_key, input ready);
  modport sink   (input valid, kind, entry_vertex, entry_key, output ready);
endinterface

@@ hw/rtl/tmhpq_rsp_if.sv @@
// Response channel interface: popped entry, status and occupancy.
interface tmhpq_rsp_if import tmhpq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [VERTEX_W-1:0] out_vertex;
  logic [KEY_W-1:0]    out_key;
  logic [STATUS_W-1:0] status;
  logic [OCC_W-1:0]    occupancy;

  modport source (output valid, out_vertex, out_key, status, occupancy, input ready);
  modport sink   (input valid, out_vertex, out_key, status, occupancy, output ready);
endinterface

@@ hw/rtl/ternary_min_heap_priority_queue_top.sv @@
// Ternary min-heap priority queue: microcoded sequencer over a single-port entry memory.
//
//   channel  direction  beat contents
//   cmd      in         kind, entry_vertex, entry_key
//   rsp      out        out_vertex, out_key, status, occupancy
//
// One command at a time; cmd.ready is high only while the sequencer idles out of reset.
// An insert checks for a full heap and raises the count; per level climbed it makes one
// registered read of the parent and moves it down. A pop reads the root and the last entry;
// per level descended it reads three children and lifts the least one if it beats the entry.
// Reset clears the entry count and the sequencer; the memory needs no clearing.
// A result waiting on rsp stalls the sequencer at its final step only.
module ternary_min_heap_priority_queue_top import tmhpq_pkg::*; (
  input logic          clk,
  input logic          rst,
  tmhpq_cmd_if.sink    cmd,
  tmhpq_rsp_if.source  rsp
);

  localparam logic [IDX_W:0] DIV3_M = (IDX_W + 1)'((2 ** (IDX_W + 1) + 2) / 3);

  logic [STEP_W-1:0]   step, step_next;
  uword_t              uw;
  logic                accept, hold, go, jump, child_ok;
  logic [CNT_W-1:0]    count;
  logic [IDX_W-1:0]    pos, par, bidx;
  logic [CHILD_W-1:0]  cidx, cidx_p1, first;
  entry_t              cur, best, rd_data, wr_data;
  logic [VERTEX_W-1:0] top_vertex;
  logic [KEY_W-1:0]    top_key;
  logic [VERTEX_W-1:0] res_vertex;
  logic [KEY_W-1:0]    res_key;
  logic [STATUS_W-1:0] res_status;
  logic [OCC_W-1:0]    res_occ;
  logic                out_valid;
  logic [IDX_W-1:0]    rd_addr, div3_x;
  logic [2*IDX_W:0]    div3_prod;
  logic                rd_en, wr_en;
  entry_t              mem [CAPACITY];

  assign uw        = ucode(step);
  assign accept    = cmd.valid && cmd.ready;
  assign cmd.ready = !rst && (step == S_IDLE);
  assign hold      = ((step == S_IDLE) && !accept) || (uw.finish && out_valid && !rsp.ready);
  assign go        = !hold;

  assign first     = CHILD_W'(pos) + CHILD_W'({pos, 1'b0}) + CHILD_W'(1);
  assign cidx_p1   = cidx + CHILD_W'(1);
  assign child_ok  = (cidx < CHILD_W'(count)) && (rd_data.key < best.key);
  assign div3_x    = pos - IDX_W'(1);
  assign div3_prod = (2 * IDX_W + 1)'(div3_x) * (2 * IDX_W + 1)'(DIV3_M);

  always_comb begin
    unique case (uw.cond)
      C_ALWAYS:       jump = 1'b1;
      C_POP:          jump = (cmd.kind == KIND_POP);
      C_FULL:         jump = (count == CNT_W'(CAPACITY));
      C_EMPTY:        jump = (count == '0);
      C_POS_ZERO:     jump = (pos == '0);
      C_CUR_NLT_RD:   jump = !(cur.key < rd_data.key);
      C_FIRST_GE:     jump = (first >= CHILD_W'(count));
      C_BEST_NLT_CUR: jump = !(best.key < cur.key);
      default:        jump = 1'b0;
    endcase
  end

  always_comb begin
    if (hold) begin
      step_next = step;
    end else if (jump) begin
      step_next = uw.target;
    end else begin
      step_next = step + STEP_W'(1);
    end
  end

  always_comb begin
    unique case (uw.rd_sel)
      RD_PAR:   rd_addr = par;
      RD_LAST:  rd_addr = count[IDX_W-1:0];
      RD_FIRST: rd_addr = first[IDX_W-1:0];
      RD_NEXT:  rd_addr = cidx_p1[IDX_W-1:0];
      default:  rd_addr = '0;
    endcase
  end

  always_comb begin
    unique case (uw.wr_sel)
      WR_RD:   wr_data = rd_data;
      WR_BEST: wr_data = best;
      default: wr_data = cur;
    endcase
  end

  assign rd_en = go && (uw.rd_sel != RD_NONE);
  assign wr_en = go && (uw.wr_sel != WR_NONE);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[pos] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      step <= step_next;
      if (go && uw.cnt_inc) begin
        count <= count + CNT_W'(1);
      end else if (go && uw.cnt_dec) begin
        count <= count - CNT_W'(1);
      end
      if (go && uw.finish) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur.vertex <= cmd.entry_vertex;
      cur.key    <= cmd.entry_key;
      pos        <= count[IDX_W-1:0];
      top_vertex <= '0;
      top_key    <= '0;
    end else if (go) begin
      if (uw.ld_par) begin
        par <= div3_prod[2*IDX_W:IDX_W+1];
      end
      unique case (uw.pos_sel)
        POS_PAR:  pos <= par;
        POS_BEST: pos <= bidx;
        POS_ZERO: pos <= '0;
        default:  pos <= pos;
      endcase
      if (uw.ld_cur) begin
        cur <= rd_data;
      end
      if (uw.ld_res) begin
        top_vertex <= rd_data.vertex;
        top_key    <= rd_data.key;
      end
      if (uw.cidx_first) begin
        cidx <= first;
      end else if (uw.cidx_inc) begin
        cidx <= cidx_p1;
      end
      if (uw.ld_best || (uw.cmp_child && child_ok)) begin
        best <= rd_data;
        bidx <= cidx[IDX_W-1:0];
      end
      if (uw.finish) begin
        res_vertex <= top_vertex;
        res_key    <= top_key;
        res_status <= uw.st;
        res_occ    <= OCC_W'(count);
      end
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.out_vertex = res_vertex;
  assign rsp.out_key    = res_key;
  assign rsp.status     = res_status;
  assign rsp.occupancy  = res_occ;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("Entry count exceeds capacity.");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (step != S_IDLE))
    else $error("Sequencer stayed idle after a command beat.");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status == ST_EMPTY)) |-> ((res_occ == '0) && (res_key == '0)))
    else $error("Pop on empty reported a non-zero entry or occupancy.");

  a_finish_only_when_free: assert property (@(posedge clk) disable iff (rst)
    (go && uw.finish) |-> (!out_valid || rsp.ready))
    else $error("Result register overwritten before its beat was taken.");
`endif

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the ternary min-heap priority queue, with its own heap predictor.
module tb;
  import tmhpq_pkg::*;

  localparam logic KIND_INSERT = ~KIND_POP;
  localparam int IDLE_LIMIT = 4000;
  localparam int RANDOM_OPS = 1500;
  localparam int DEEP_FILL = 400;
  localparam logic [VERTEX_W-1:0] VERTEX_MAX = '1;
  localparam logic [KEY_W-1:0] KEY_MAX = '1;
  localparam int DIRECTED_ROWS = 25;

  typedef struct packed {
    logic [VERTEX_W-1:0] vertex;
    logic [KEY_W-1:0]    key;
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occupancy;
  } rsp_beat_t;

  typedef struct {
    logic                kind;
    logic [VERTEX_W-1:0] vertex;
    logic [KEY_W-1:0]    key;
    bit                  typed;
    rsp_beat_t           want;
  } op_row_t;

  typedef enum int {KEYS_WIDE, KEYS_TIED, KEYS_EXTREME, KEYS_NARROW} key_mix_t;

  logic clk;
  logic rst;
  bit   calm;

  tmhpq_cmd_if cmd_ch ();
  tmhpq_rsp_if rsp_ch ();

  ternary_min_heap_priority_queue_top u_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  entry_t      heap_img [CAPACITY];
  int unsigned heap_fill;
  rsp_beat_t   heap_result_q [$];
  rsp_beat_t   owed;

  int n_errors;
  int n_inserts;
  int n_dropped;
  int n_pops;
  int n_empty_pops;
  int n_beats;
  int peak_fill;
  int quiet_cycles;

  op_row_t directed [DIRECTED_ROWS];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic rsp_beat_t apply_heap_op(input logic kind,
                                              input logic [VERTEX_W-1:0] vertex,
                                              input logic [KEY_W-1:0] key);
    rsp_beat_t   r;
    entry_t      t;
    int unsigned pos;
    int unsigned parent;
    int unsigned first;
    int unsigned best;
    int unsigned c;
    r = '0;
    r.status = ST_DONE;
    if (kind == KIND_INSERT) begin
      n_inserts++;
      if (heap_fill >= CAPACITY) begin
        r.status = ST_FULL;
        n_dropped++;
      end else begin
        pos = heap_fill;
        heap_img[pos] = {vertex, key};
        heap_fill++;
        while (pos > 0) begin
          parent = (pos - 1) / 3;
          if (heap_img[pos].key >= heap_img[parent].key) break;
          t = heap_img[pos];
          heap_img[pos] = heap_img[parent];
          heap_img[parent] = t;
          pos = parent;
        end
      end
    end else begin
      n_pops++;
      if (heap_fill == 0) begin
        r.status = ST_EMPTY;
        n_empty_pops++;
      end else begin
        r.vertex = heap_img[0].vertex;
        r.key = heap_img[0].key;
        heap_fill--;
        heap_img[0] = heap_img[heap_fill];
        pos = 0;
        while (1) begin
          first = 3 * pos + 1;
          if (first >= heap_fill) break;
          best = first;
          for (c = first + 1; c <= first + 2 && c < heap_fill; c++) begin
            if (heap_img[c].key < heap_img[best].key) best = c;
          end
          if (heap_img[best].key >= heap_img[pos].key) break;
          t = heap_img[pos];
          heap_img[pos] = heap_img[best];
          heap_img[best] = t;
          pos = best;
        end
      end
    end
    if (heap_fill > peak_fill) peak_fill = heap_fill;
    r.occupancy = OCC_W'(heap_fill);
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [KEY_W-1:0] pick_key(input key_mix_t mix);
    int roll;
    roll = $urandom_range(0, 3);
    case (mix)
      KEYS_TIED: return KEY_W'($urandom_range(0, 7));
      KEYS_NARROW: return KEY_W'($urandom_range(0, 1000));
      KEYS_EXTREME: begin
        if (roll == 0) return '0;
        if (roll == 1) return KEY_MAX;
        if (roll == 2) return KEY_MAX - 1;
        return KEY_W'(1);
      end
      default: return KEY_W'($urandom());
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned wanted);
    n_errors++;
    if (n_errors <= 40) $display("%0t: %s got %0h, wanted %0h", $time, what, got, wanted);
  endtask

  task automatic send_op(input logic kind, input logic [VERTEX_W-1:0] vertex,
                         input logic [KEY_W-1:0] key, input bit typed, input rsp_beat_t want);
    rsp_beat_t predicted;
    int        gap;
    cmd_ch.valid        <= 1'b1;
    cmd_ch.kind         <= kind;
    cmd_ch.entry_vertex <= vertex;
    cmd_ch.entry_key    <= key;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    predicted = apply_heap_op(kind, vertex, key);
    heap_result_q.insert(heap_result_q.size(), typed ? want : predicted);
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic rand_op(input int pop_pct, input key_mix_t mix);
    logic kind;
    kind = ($urandom_range(0, 99) < pop_pct) ? KIND_POP : KIND_INSERT;
    send_op(kind, VERTEX_W'($urandom()), pick_key(mix), 1'b0, '0);
  endtask

  task automatic hold_until_drained();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (heap_result_q.size() != 0) @(posedge clk);
  endtask

  // Drains, inserts descending keys (each a new root) then random keys, mixes ops and drains.
  task automatic fill_and_drain(output int sent);
    int unsigned step;
    logic [KEY_W-1:0] key;
    sent = 0;
    while (heap_fill > 0) begin
      rand_op(100, KEYS_WIDE);
      sent++;
    end
    step = 0;
    while (step < DEEP_FILL) begin
      key = (step < DEEP_FILL / 2) ? KEY_MAX - KEY_W'(step * 400000) : pick_key(KEYS_WIDE);
      send_op(KIND_INSERT, VERTEX_W'($urandom()), key, 1'b0, '0);
      step++;
      sent++;
    end
    repeat (40) begin
      rand_op(50, KEYS_NARROW);
      sent++;
    end
    while (heap_fill > 0) begin
      rand_op(100, KEYS_WIDE);
      sent++;
    end
  endtask

  initial begin
    directed = '{
      '{KIND_POP,    20'h0,      31'h0,        1'b1, {20'h0, 31'h0, ST_EMPTY, 13'd0}},
      '{KIND_INSERT, VERTEX_MAX, KEY_MAX,      1'b1, {20'h0, 31'h0, ST_DONE, 13'd1}},
      '{KIND_INSERT, 20'h0,      31'h0,        1'b1, {20'h0, 31'h0, ST_DONE, 13'd2}},
      '{KIND_POP,    VERTEX_MAX, KEY_MAX,      1'b1, {20'h0, 31'h0, ST_DONE, 13'd1}},
      '{KIND_POP,    20'h0,      31'h0,        1'b1, {VERTEX_MAX, KEY_MAX, ST_DONE, 13'd0}},
      '{KIND_POP,    20'h0,      31'h0,        1'b1, {20'h0, 31'h0, ST_EMPTY, 13'd0}},
      '{KIND_INSERT, 20'h1,      31'h5,        1'b0, '0},
      '{KIND_INSERT, 20'h2,      31'h5,        1'b0, '0},
      '{KIND_INSERT, 20'h3,      31'h5,        1'b0, '0},
      '{KIND_INSERT, 20'h4,      31'h5,        1'b0, '0},
      '{KIND_INSERT, 20'h5,      31'h3,        1'b0, '0},
      '{KIND_INSERT, 20'h6,      31'h5,        1'b0, '0},
      '{KIND_POP,    20'h0,      31'h0,        1'b0, '0},
      '{KIND_POP,    20'h0,      31'h0,        1'b0, '0},
      '{KIND_POP,    20'h0,      31'h0,        1'b0, '0},
      '{KIND_POP,    20'h0,      31'h0,        1'b0, '0},
      '{KIND_POP,    20'h0,      31'h0,        1'b0, '0},
      '{KIND_POP,    20'h0,      31'h0,        1'b0, '0},
      '{KIND_INSERT, 20'h55555,  31'h2AAAAAAA, 1'b0, '0},
      '{KIND_INSERT, 20'hAAAAA,  31'h55555555, 1'b0, '0},
      '{KIND_INSERT, 20'hABCDE,  31'h55555555, 1'b0, '0},
      '{KIND_POP,    20'h0,      31'h0,        1'b0, '0},
      '{KIND_POP,    20'h0,      31'h0,        1'b0, '0},
      '{KIND_POP,    20'h0,      31'h0,        1'b0, '0},
      '{KIND_POP,    20'h0,      31'h0,        1'b1, {20'h0, 31'h0, ST_EMPTY, 13'd0}}
    };
  end

  initial begin
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      rsp_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      if (!calm) begin
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
          rsp_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      n_beats++;
      if (heap_result_q.size() == 0) begin
        report_mismatch("response beat with nothing outstanding, status", rsp_ch.status, 0);
      end else begin
        owed = heap_result_q.pop_front();
        if (rsp_ch.out_vertex !== owed.vertex)
          report_mismatch("out_vertex", rsp_ch.out_vertex, owed.vertex);
        if (rsp_ch.out_key !== owed.key)
          report_mismatch("out_key", rsp_ch.out_key, owed.key);
        if (rsp_ch.status !== owed.status)
          report_mismatch("status", rsp_ch.status, owed.status);
        if (rsp_ch.occupancy !== owed.occupancy)
          report_mismatch("occupancy", rsp_ch.occupancy, owed.occupancy);
      end
    end
  end

  always @(posedge clk) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no beat for %0d cycles, %0d responses outstanding.",
               quiet_cycles, heap_result_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int       done_ops;
    int       fill_ops;
    int       phase_len;
    int       pop_pct;
    bit       filled;
    key_mix_t mix;
    rst                 <= 1'b1;
    cmd_ch.valid        <= 1'b0;
    cmd_ch.kind         <= KIND_INSERT;
    cmd_ch.entry_vertex <= '0;
    cmd_ch.entry_key    <= '0;
    calm = 1'b0;
    heap_fill = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      send_op(directed[i].kind, directed[i].vertex, directed[i].key,
              directed[i].typed, directed[i].want);
    end
    hold_until_drained();

    done_ops = 0;
    filled = 1'b0;
    while (done_ops < RANDOM_OPS) begin
      calm = ($urandom_range(0, 3) == 0);
      mix = key_mix_t'($urandom_range(0, 3));
      if (!filled && done_ops >= RANDOM_OPS / 2) begin
        fill_and_drain(fill_ops);
        done_ops += fill_ops;
        filled = 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
        while (heap_fill > 0) begin
          rand_op(100, mix);
          done_ops++;
        end
        rand_op(100, mix);
        done_ops++;
      end else begin
        phase_len = $urandom_range(40, 150);
        pop_pct = $urandom_range(25, 65);
        repeat (phase_len) begin
          rand_op(pop_pct, mix);
          done_ops++;
        end
      end
      if ($urandom_range(0, 3) == 0) hold_until_drained();
    end

    calm = 1'b0;
    cmd_ch.valid <= 1'b0;
    while (heap_result_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("Covered %0d inserts (%0d dropped on a full heap) and %0d pops (%0d on empty).",
             n_inserts, n_dropped, n_pops, n_empty_pops);
    $display("Checked %0d response beats; peak occupancy %0d of %0d, %0d errors.",
             n_beats, peak_fill, CAPACITY, n_errors);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
